FILE: rtl/psq_pkg.sv
// ----------------------------------------------------------------------------
// psq_pkg
// Types and codes shared by the positional sequence store.
// ----------------------------------------------------------------------------
`default_nettype none

package psq_pkg;

    localparam int DATA_W = 32;
    localparam int MODE_W = 3;
    localparam int POS_W  = 8;
    localparam int LEN_W  = 5;
    localparam int STAT_W = 2;

    typedef logic signed [DATA_W-1:0] t_data;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_BACK  = 3'd0,
        MODE_PUSH_FRONT = 3'd1,
        MODE_INSERT_AT  = 3'd2,
        MODE_REM_FRONT  = 3'd3,
        MODE_REM_BACK   = 3'd4,
        MODE_REM_AT     = 3'd5,
        MODE_DUMP       = 3'd6
    } t_mode;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXTR,
        S_DUMP
    } t_state;

    // Broadcast to every cell of the chain
    typedef struct packed {
        logic ins;  // open a gap at pos and write the new value there
        logic rem;  // close the gap at pos, capture the removed value
        logic rot;  // rotate the occupied cells left by one
        logic xsh;  // move the extraction lane one cell towards the head
    } t_cell_cmd;

endpackage

`default_nettype wire

FILE: rtl/psq_if.sv
// ----------------------------------------------------------------------------
// psq_in_if / psq_out_if
// Valid/ready channels carrying operation items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface psq_in_if;
    import psq_pkg::*;
    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    t_data               value;
    logic [POS_W-1:0]    position;

    modport source (output valid, mode, value, position, input ready);
    modport sink   (input valid, mode, value, position, output ready);
endinterface

interface psq_out_if;
    import psq_pkg::*;
    logic                valid;
    logic                ready;
    t_data               value_out;
    logic [LEN_W-1:0]    length;
    logic [STAT_W-1:0]   status;
    logic                last;

    modport source (output valid, value_out, length, status, last, input ready);
    modport sink   (input valid, value_out, length, status, last, output ready);
endinterface

`default_nettype wire

FILE: rtl/psq_cell.sv
// ----------------------------------------------------------------------------
// psq_cell
// One list slot: holds its element and one stage of the extraction lane.
// ----------------------------------------------------------------------------
`default_nettype none

module psq_cell #(
    parameter int IDX = 0,
    parameter int W   = 5
) (
    input  wire                  i_clk,
    input  psq_pkg::t_cell_cmd   i_cmd,
    input  wire [W-1:0]          i_pos,
    input  wire [W-1:0]          i_last,
    input  psq_pkg::t_data       i_new,
    input  psq_pkg::t_data       i_left,
    input  psq_pkg::t_data       i_right,
    input  psq_pkg::t_data       i_head,
    input  psq_pkg::t_data       i_ext_right,
    output psq_pkg::t_data       o_val,
    output psq_pkg::t_data       o_ext
);
    import psq_pkg::*;

    localparam logic [W-1:0] IDX_W = W'(IDX);

    t_data r_val;
    t_data r_ext;

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins) begin
            if (IDX_W == i_pos) begin
                r_val <= i_new;
            end else if (IDX_W > i_pos) begin
                r_val <= i_left;
            end
        end else if (i_cmd.rem) begin
            if (IDX_W >= i_pos) begin
                r_val <= i_right;
            end
        end else if (i_cmd.rot) begin
            // tail slot wraps round to the old head
            if (IDX_W == i_last) begin
                r_val <= i_head;
            end else if (IDX_W < i_last) begin
                r_val <= i_right;
            end
        end

        if (i_cmd.rem && (IDX_W == i_pos)) begin
            r_ext <= r_val;
        end else if (i_cmd.xsh) begin
            r_ext <= i_ext_right;
        end
    end

    assign o_val = r_val;
    assign o_ext = r_ext;

endmodule

`default_nettype wire

FILE: rtl/positional_sequence_store.sv
// ----------------------------------------------------------------------------
// positional_sequence_store
// Bounded ordered list with push, positional insert/remove and dump.
// ----------------------------------------------------------------------------
// The list lives in a row of CAPACITY cells, one element per cell, with the
// head in cell 0. Push back, push front, insert at and remove front act as
// the item is accepted: cells from the position onward shift by one cell and
// the result is loaded with that shift. A removal at position p > 0 (remove
// back, remove at) moves the element into an extraction lane as the item is
// accepted; it then travels to the head, one cell per cycle, and the result
// is loaded once the output register is free. A dump loads the elements one
// by one, each when the output register is free; the row rotates once per
// element and ends in its original order. Rejected operations (full, empty,
// out of range) and the unused mode load their result on acceptance. A new
// item is accepted only in the idle state and when the output register is
// empty or its result leaves in the same cycle; no clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_sequence_store #(
    parameter int CAPACITY = 16
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    psq_in_if.sink     i_in,
    psq_out_if.source  o_out
);
    import psq_pkg::*;

    localparam int W  = $clog2(CAPACITY + 1);
    localparam int XW = (W > POS_W) ? W : POS_W;
    localparam logic [W-1:0] CAP_W = W'(CAPACITY);
    localparam logic [W-1:0] ONE_W = W'(1);

    t_state          r_state, n_state;
    logic [W-1:0]    r_count, n_count;
    logic [W-1:0]    r_xcnt,  n_xcnt;
    logic [W-1:0]    r_dcnt,  n_dcnt;

    logic            r_ov;
    t_data           r_oval;
    logic [LEN_W-1:0] r_olen;
    t_status         r_ost;
    logic            r_olast;

    t_cell_cmd       cmd;
    logic [W-1:0]    sel_pos;
    logic [W-1:0]    last_idx;

    logic            acc, o_free;
    logic            ld;
    t_data           ld_val;
    logic [W-1:0]    ld_len;
    t_status         ld_st;
    logic            ld_last;

    logic [XW-1:0]   pos_x, cnt_x, len_x;
    logic [W-1:0]    ins_pos;
    logic            dump_last;

    t_data           w_val [CAPACITY];
    t_data           w_ext [CAPACITY];

    assign o_free     = !r_ov || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE) && o_free;
    assign acc        = i_in.valid && i_in.ready;

    assign pos_x     = XW'(i_in.position);
    assign cnt_x     = XW'(r_count);
    assign last_idx  = r_count - ONE_W;
    assign dump_last = (r_dcnt == last_idx);

    // insert position clamped to the current length
    always_comb begin
        case (i_in.mode)
            MODE_PUSH_FRONT: ins_pos = '0;
            MODE_INSERT_AT:  ins_pos = (pos_x > cnt_x) ? r_count : pos_x[W-1:0];
            default:         ins_pos = r_count;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_xcnt  = r_xcnt;
        n_dcnt  = r_dcnt;
        cmd     = '0;
        sel_pos = ins_pos;
        ld      = 1'b0;
        ld_val  = '0;
        ld_len  = r_count;
        ld_st   = ST_OK;
        ld_last = 1'b1;

        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    case (i_in.mode)
                        MODE_PUSH_BACK, MODE_PUSH_FRONT, MODE_INSERT_AT: begin
                            ld = 1'b1;
                            if (r_count >= CAP_W) begin
                                ld_st = ST_FULL;
                            end else begin
                                cmd.ins = 1'b1;
                                n_count = r_count + ONE_W;
                                ld_len  = n_count;
                            end
                        end
                        MODE_REM_FRONT, MODE_REM_BACK, MODE_REM_AT: begin
                            if (i_in.mode == MODE_REM_FRONT) begin
                                sel_pos = '0;
                            end else if (i_in.mode == MODE_REM_BACK) begin
                                sel_pos = last_idx;
                            end else begin
                                sel_pos = pos_x[W-1:0];
                            end
                            if (r_count == '0) begin
                                ld    = 1'b1;
                                ld_st = ST_EMPTY;
                            end else if ((i_in.mode == MODE_REM_AT) && (pos_x >= cnt_x)) begin
                                ld    = 1'b1;
                                ld_st = ST_RANGE;
                            end else begin
                                cmd.rem = 1'b1;
                                n_count = r_count - ONE_W;
                                if (sel_pos == '0) begin
                                    ld     = 1'b1;
                                    ld_val = w_val[0];
                                    ld_len = n_count;
                                end else begin
                                    n_state = S_EXTR;
                                    n_xcnt  = sel_pos;
                                end
                            end
                        end
                        MODE_DUMP: begin
                            if (r_count == '0) begin
                                ld    = 1'b1;
                                ld_st = ST_EMPTY;
                            end else begin
                                n_state = S_DUMP;
                                n_dcnt  = '0;
                            end
                        end
                        default: begin
                            ld = 1'b1;
                        end
                    endcase
                end
            end
            S_EXTR: begin
                if (r_xcnt != '0) begin
                    cmd.xsh = 1'b1;
                    n_xcnt  = r_xcnt - ONE_W;
                end else if (o_free) begin
                    ld      = 1'b1;
                    ld_val  = w_ext[0];
                    n_state = S_IDLE;
                end
            end
            S_DUMP: begin
                if (o_free) begin
                    cmd.rot = 1'b1;
                    ld      = 1'b1;
                    ld_val  = w_val[0];
                    ld_last = dump_last;
                    if (dump_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_dcnt = r_dcnt + ONE_W;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign len_x = XW'(ld_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_xcnt  <= '0;
            r_dcnt  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_xcnt  <= n_xcnt;
            r_dcnt  <= n_dcnt;
            if (ld) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld) begin
            r_oval  <= ld_val;
            r_olen  <= len_x[LEN_W-1:0];
            r_ost   <= ld_st;
            r_olast <= ld_last;
        end
    end

    assign o_out.valid     = r_ov;
    assign o_out.value_out = r_oval;
    assign o_out.length    = r_olen;
    assign o_out.status    = r_ost;
    assign o_out.last      = r_olast;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_data left_v, right_v, ext_r;
        if (g == 0) begin : g_head
            assign left_v = i_in.value;
        end else begin : g_body
            assign left_v = w_val[g-1];
        end
        if (g == CAPACITY - 1) begin : g_tail
            assign right_v = w_val[g];
            assign ext_r   = w_ext[g];
        end else begin : g_inner
            assign right_v = w_val[g+1];
            assign ext_r   = w_ext[g+1];
        end

        psq_cell #(
            .IDX (g),
            .W   (W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_cmd       (cmd),
            .i_pos       (sel_pos),
            .i_last      (last_idx),
            .i_new       (i_in.value),
            .i_left      (left_v),
            .i_right     (right_v),
            .i_head      (w_val[0]),
            .i_ext_right (ext_r),
            .o_val       (w_val[g]),
            .o_ext       (w_ext[g])
        );
    end

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_W)
        else $error("element count above capacity");

    a_push_grows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && cmd.ins) |=> (r_count == $past(r_count) + ONE_W))
        else $error("accepted insert did not grow the list");

    a_dump_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DUMP) |=> $stable(r_count))
        else $error("length changed during dump");

    a_dump_ends : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DUMP && ld && dump_last) |=> (r_state == S_IDLE && r_olast))
        else $error("dump did not finish on its final item");

endmodule

`default_nettype wire

FILE: bench/psq_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// psq_result_checker
// Watches both channels of the positional sequence store. It keeps its own
// copy of the list, works out the results that each accepted operation should
// give and compares every accepted result, field by field, in order.
// ----------------------------------------------------------------------------

module psq_result_checker #(
    parameter int CAPACITY = 16
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    psq_in_if    in_mon,
    psq_out_if   out_mon,
    output int   o_fail_count,
    output int   o_pending
);
    import psq_pkg::*;

    typedef struct {
        t_data             value_out;
        logic [LEN_W-1:0]  length;
        t_status           status;
        logic              last;
    } t_result;

    t_result  awaited_q[$];
    t_data    list_mem[CAPACITY];
    int       list_len   = 0;
    int       fail_total = 0;

    // length is taken after the operation has been applied
    function automatic void post_result(t_data v, t_status st, logic lst);
        t_result r;
        r.value_out = v;
        r.length    = list_len[LEN_W-1:0];
        r.status    = st;
        r.last      = lst;
        awaited_q.push_back(r);
    endfunction

    function automatic void apply_op(logic [MODE_W-1:0] m, t_data v, logic [POS_W-1:0] p);
        int    idx;
        t_data taken;
        case (m)
            MODE_PUSH_BACK, MODE_PUSH_FRONT, MODE_INSERT_AT: begin
                if (list_len >= CAPACITY) begin
                    post_result('0, ST_FULL, 1'b1);
                end else begin
                    if (m == MODE_PUSH_BACK)
                        idx = list_len;
                    else if (m == MODE_PUSH_FRONT)
                        idx = 0;
                    else
                        idx = (int'(p) > list_len) ? list_len : int'(p);  // clamp: append
                    for (int i = list_len; i > idx; i--)
                        list_mem[i] = list_mem[i-1];
                    list_mem[idx] = v;
                    list_len++;
                    post_result('0, ST_OK, 1'b1);
                end
            end
            MODE_REM_FRONT, MODE_REM_BACK, MODE_REM_AT: begin
                if (list_len == 0) begin
                    post_result('0, ST_EMPTY, 1'b1);
                end else if (m == MODE_REM_AT && int'(p) >= list_len) begin
                    post_result('0, ST_RANGE, 1'b1);
                end else begin
                    if (m == MODE_REM_FRONT)
                        idx = 0;
                    else if (m == MODE_REM_BACK)
                        idx = list_len - 1;
                    else
                        idx = int'(p);
                    taken = list_mem[idx];
                    for (int i = idx; i + 1 < list_len; i++)
                        list_mem[i] = list_mem[i+1];
                    list_len--;
                    post_result(taken, ST_OK, 1'b1);
                end
            end
            MODE_DUMP: begin
                if (list_len == 0) begin
                    post_result('0, ST_EMPTY, 1'b1);
                end else begin
                    for (int i = 0; i < list_len; i++)
                        post_result(list_mem[i], ST_OK, i == list_len - 1);
                end
            end
            default: begin
                post_result('0, ST_OK, 1'b1);
            end
        endcase
    endfunction

    function automatic void check_field(string name, logic [DATA_W-1:0] want,
                                        logic [DATA_W-1:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
            fail_total++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result head;
        if (!i_rst_n) begin
            awaited_q.delete();
            list_len = 0;
        end else begin
            // prediction first, in case a result could follow its item at once
            if (in_mon.valid && in_mon.ready)
                apply_op(in_mon.mode, in_mon.value, in_mon.position);
            if (out_mon.valid && out_mon.ready) begin
                if (awaited_q.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, actual %h/%0d/%0d/%0b",
                             $time, out_mon.value_out, out_mon.length, out_mon.status,
                             out_mon.last);
                    fail_total++;
                end else begin
                    head = awaited_q.pop_front();
                    check_field("value_out", head.value_out, out_mon.value_out);
                    check_field("length", DATA_W'(head.length), DATA_W'(out_mon.length));
                    check_field("status", DATA_W'(head.status), DATA_W'(out_mon.status));
                    check_field("last", DATA_W'(head.last), DATA_W'(out_mon.last));
                end
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= awaited_q.size();
    end

endmodule

FILE: bench/positional_sequence_store_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// positional_sequence_store_tb
// Drives operations into the positional sequence store: a directed opening
// over the corner cases, then random fill, drain and mixed runs, with random
// gaps on both channels and one long output hold-off. Checking is done by
// psq_result_checker; this module gives the verdict.
// ----------------------------------------------------------------------------

module positional_sequence_store_tb;
    import psq_pkg::*;

    localparam int     CAPACITY    = 16;
    localparam int     CLK_PERIOD  = 10;
    localparam int     N_ITEMS     = 350;
    localparam int     LONG_HOLD   = 120;
    localparam int     TAIL_CYCLES = 40;
    localparam longint LIMIT_NS    = 15_000_000;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    psq_in_if  op_ch ();
    psq_out_if res_ch ();

    int fail_count;
    int pending;
    int list_len   = 0;   // occupancy only, used to shape the stimulus
    int items_sent = 0;
    bit tx_calm    = 1'b0;
    bit hold_req   = 1'b0;

    positional_sequence_store #(
        .CAPACITY (CAPACITY)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (op_ch.sink),
        .o_out   (res_ch.source)
    );

    psq_result_checker #(
        .CAPACITY (CAPACITY)
    ) results_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_mon       (op_ch),
        .out_mon      (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        #(LIMIT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_data pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return -1;
            default: return t_data'($urandom);
        endcase
    endfunction

    function automatic logic [POS_W-1:0] pick_pos(int span);
        if (span <= 0 || $urandom_range(0, 4) == 0)
            return POS_W'($urandom_range(0, 255));
        return POS_W'($urandom_range(0, span));
    endfunction

    function automatic logic [MODE_W-1:0] pick_insert();
        case ($urandom_range(0, 2))
            0:       return MODE_PUSH_BACK;
            1:       return MODE_PUSH_FRONT;
            default: return MODE_INSERT_AT;
        endcase
    endfunction

    function automatic logic [MODE_W-1:0] pick_remove();
        case ($urandom_range(0, 2))
            0:       return MODE_REM_FRONT;
            1:       return MODE_REM_BACK;
            default: return MODE_REM_AT;
        endcase
    endfunction

    task automatic send_op(logic [MODE_W-1:0] m, t_data v, logic [POS_W-1:0] p);
        int gap;
        gap = tx_calm ? 0 : pick_gap();
        if (gap > 0) begin
            op_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        op_ch.valid    <= 1'b1;
        op_ch.mode     <= m;
        op_ch.value    <= v;
        op_ch.position <= p;
        do @(posedge i_clk); while (!op_ch.ready);
        items_sent++;
        case (m)
            MODE_PUSH_BACK, MODE_PUSH_FRONT, MODE_INSERT_AT:
                if (list_len < CAPACITY) list_len++;
            MODE_REM_FRONT, MODE_REM_BACK:
                if (list_len > 0) list_len--;
            MODE_REM_AT:
                if (list_len > 0 && int'(p) < list_len) list_len--;
            default: ;
        endcase
    endtask

    task automatic fill_run();
        while (list_len < CAPACITY)
            send_op(pick_insert(), pick_value(), pick_pos(list_len));
        repeat ($urandom_range(1, 3))
            send_op(pick_insert(), pick_value(), pick_pos(list_len));
    endtask

    task automatic drain_run();
        while (list_len > 0)
            send_op(pick_remove(), pick_value(), pick_pos(list_len - 1));
        repeat ($urandom_range(1, 2))
            send_op(pick_remove(), pick_value(), pick_pos(0));
    endtask

    task automatic mixed_run(int n);
        logic [MODE_W-1:0] m;
        repeat (n) begin
            case ($urandom_range(0, 15))
                0, 1, 2, 3, 4, 5: m = pick_insert();
                6, 7, 8, 9, 10:   m = pick_remove();
                11, 12:           m = MODE_DUMP;
                13:               m = MODE_UNUSED;
                default:          m = MODE_INSERT_AT;
            endcase
            send_op(m, pick_value(), pick_pos(list_len));
        end
    endtask

    // output side: random stalls, calm stretches, and the long hold-off
    initial begin
        bit hold_seen;
        bit rx_calm;
        int calm_left;
        int gap;
        hold_seen = 1'b0;
        rx_calm   = 1'b0;
        calm_left = $urandom_range(50, 300);
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (--calm_left == 0) begin
                rx_calm   = ~rx_calm;
                calm_left = $urandom_range(50, 300);
            end
            if (hold_seen != hold_req) begin
                hold_seen = hold_req;
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                res_ch.ready <= 1'b1;
            end else begin
                gap = rx_calm ? 0 : pick_gap();
                if (gap > 0) begin
                    res_ch.ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                res_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        int bursts;
        op_ch.valid    <= 1'b0;
        op_ch.mode     <= MODE_PUSH_BACK;
        op_ch.value    <= '0;
        op_ch.position <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty list cases, unused mode, removal of the only element
        send_op(MODE_DUMP, '0, '0);
        send_op(MODE_REM_FRONT, '0, '0);
        send_op(MODE_REM_BACK, '0, '0);
        send_op(MODE_REM_AT, '0, '0);
        send_op(MODE_UNUSED, -1, 8'hFF);
        send_op(MODE_PUSH_BACK, 32'sh7FFF_FFFF, '0);
        send_op(MODE_REM_BACK, '0, '0);
        // insert beyond the end clamps to an append
        send_op(MODE_PUSH_FRONT, 32'sh8000_0000, '0);
        send_op(MODE_INSERT_AT, -1, 8'hFF);
        send_op(MODE_INSERT_AT, '0, 8'd1);
        send_op(MODE_INSERT_AT, 32'sh5A5A_A5A5, '0);
        // removal positions past the end
        send_op(MODE_REM_AT, '0, 8'hFF);
        send_op(MODE_REM_AT, '0, 8'd4);
        send_op(MODE_DUMP, '0, '0);
        send_op(MODE_REM_AT, '0, 8'd2);
        send_op(MODE_REM_FRONT, '0, '0);
        send_op(MODE_DUMP, '0, '0);

        // first run always fills, so the full cases come early
        bursts = 0;
        fill_run();
        send_op(MODE_DUMP, '0, '0);
        while (items_sent < N_ITEMS) begin
            bursts++;
            tx_calm = ($urandom_range(0, 3) == 0);
            if (bursts == 2) begin
                // keep offering items while the output is held off
                tx_calm  = 1'b1;
                hold_req = ~hold_req;
                mixed_run(30);
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2: fill_run();
                    3, 4, 5: drain_run();
                    default: mixed_run($urandom_range(10, 30));
                endcase
            end
            if ($urandom_range(0, 1) == 0)
                send_op(MODE_DUMP, '0, '0);
        end
        tx_calm = 1'b0;
        op_ch.valid <= 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
